>>> design/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

    localparam int STORE_DEPTH     = 16;
    localparam int WINDOW_MAX      = 8;
    localparam int MAX_FRAME_BYTES = 416;

    localparam int SEQ_W  = 32;
    localparam int REF_W  = 32;
    localparam int LEN_W  = 9;
    localparam int OP_W   = 2;
    localparam int CFG_W  = 4;
    localparam int DESC_W = REF_W + LEN_W;
    localparam int SLOT_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [APB_AW-3:0] {
        REG_WINDOW_SIZE = 1'b0
    } t_reg;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [DESC_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    // Sequence number s is kept in entry (s - 1) mod STORE_DEPTH; the depth is a power of two.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] base;
        base = seq - SEQ_W'(1);
        return base[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/gbn_req_if.sv
`default_nettype none

interface gbn_req_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [REF_W-1:0] frame_ref;
    logic [LEN_W-1:0] frame_len;
    logic [SEQ_W-1:0] ack_num;

    modport source (output valid, output op, output frame_ref, output frame_len,
                    output ack_num, input ready);
    modport sink (input valid, input op, input frame_ref, input frame_len,
                  input ack_num, output ready);
endinterface

`default_nettype wire

>>> design/gbn_res_if.sv
`default_nettype none

interface gbn_res_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [SEQ_W-1:0] seq_num;
    logic [REF_W-1:0] tx_ref;
    logic [LEN_W-1:0] tx_len;
    logic             last;

    modport source (output valid, output status, output seq_num, output tx_ref,
                    output tx_len, output last, input ready);
    modport sink (input valid, input status, input seq_num, input tx_ref,
                  input tx_len, input last, output ready);
endinterface

`default_nettype wire

>>> design/gbn_ram.sv
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/gbn_cfg.sv
`default_nettype none

module gbn_cfg import gbn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready,
    output      logic [CNT_W-1:0]  o_win
);

    logic [CFG_W-1:0] r_win_size;
    logic [CFG_W-1:0] n_win_size;
    logic             sel_win;

    assign sel_win = (t_reg'(paddr[APB_AW-1:2]) == REG_WINDOW_SIZE);

    always_comb begin
        n_win_size = r_win_size;
        if (psel && penable && pwrite && sel_win) begin
            n_win_size = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_RESET;
        end else begin
            r_win_size <= n_win_size;
        end
    end

    // A window of zero behaves as one, and anything above the maximum as the maximum.
    always_comb begin
        if (r_win_size == '0) begin
            o_win = CNT_W'(1);
        end else if (32'(r_win_size) > 32'(WINDOW_MAX)) begin
            o_win = CNT_W'(WINDOW_MAX);
        end else begin
            o_win = CNT_W'(r_win_size);
        end
    end

    assign prdata = sel_win ? APB_DW'(r_win_size) : '0;
    assign pready = 1'b1;

endmodule

`default_nettype wire

>>> design/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gbn_req_if.sink                i_req,
    gbn_res_if.source              o_res,
    input  wire logic [CNT_W-1:0]  i_win,
    output      t_ram_req          o_ram,
    input  wire logic [DESC_W-1:0] i_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic             r_retx, n_retx;
    logic [SEQ_W-1:0] r_low, n_low;
    logic [SEQ_W-1:0] r_high, n_high;
    logic [SEQ_W-1:0] r_stored, n_stored;
    logic [SEQ_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_status, n_status;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [REF_W-1:0] r_ref, n_ref;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_last, n_last;

    logic             req_fire;
    logic             res_fire;
    logic [SEQ_W-1:0] win;
    logic [SEQ_W-1:0] held;
    logic             full;
    logic [LEN_W-1:0] len_clamp;
    logic             ack_ok;
    logic             go;
    logic             more;
    logic [CNT_W-1:0] k_next;

    assign req_fire  = i_req.valid && i_req.ready;
    assign res_fire  = o_res.valid && o_res.ready;
    assign win       = SEQ_W'(i_win);
    assign held      = r_stored - (r_low - SEQ_W'(1));
    assign full      = held >= SEQ_W'(STORE_DEPTH);
    assign len_clamp = (32'(i_req.frame_len) > 32'(MAX_FRAME_BYTES)) ?
                       LEN_W'(MAX_FRAME_BYTES) : i_req.frame_len;
    assign ack_ok    = (i_req.ack_num - r_low) < (r_high - r_low);
    assign k_next    = r_k + CNT_W'(1);

    // The first frame of a burst is checked here; later ones are looked ahead at emission.
    always_comb begin
        if (r_retx) begin
            go = (r_cur != r_high) && (r_k < CNT_W'(WINDOW_MAX));
        end else begin
            go = ((r_high - SEQ_W'(1)) != r_stored) && ((r_high - r_low) < win) &&
                 (r_k < CNT_W'(WINDOW_MAX));
        end
    end

    always_comb begin
        if (r_retx) begin
            more = ((r_cur + SEQ_W'(1)) != r_high) && (k_next < CNT_W'(WINDOW_MAX));
        end else begin
            more = (r_high != r_stored) && ((r_high + SEQ_W'(1) - r_low) < win) &&
                   (k_next < CNT_W'(WINDOW_MAX));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_retx   = r_retx;
        n_low    = r_low;
        n_high   = r_high;
        n_stored = r_stored;
        n_cur    = r_cur;
        n_k      = r_k;
        n_status = r_status;
        n_seq    = r_seq;
        n_ref    = r_ref;
        n_len    = r_len;
        n_last   = r_last;
        o_ram.we    = 1'b0;
        o_ram.waddr = slot_of(r_stored + SEQ_W'(1));
        o_ram.wdata = {i_req.frame_ref, len_clamp};
        o_ram.raddr = slot_of(r_cur);

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cur  = r_high;
                    n_k    = '0;
                    n_retx = 1'b0;
                    unique case (t_op'(i_req.op))
                        OP_SEND: begin
                            if (full) begin
                                n_status = 1'b1;
                                n_seq    = '0;
                                n_ref    = '0;
                                n_len    = '0;
                                n_last   = 1'b1;
                                n_state  = S_OUT;
                            end else begin
                                o_ram.we = 1'b1;
                                n_stored = r_stored + SEQ_W'(1);
                                n_state  = S_CHECK;
                            end
                        end
                        OP_ACK: begin
                            if (ack_ok) begin
                                n_low   = i_req.ack_num + SEQ_W'(1);
                                n_state = S_CHECK;
                            end
                        end
                        OP_TIMEOUT: begin
                            n_retx  = 1'b1;
                            n_cur   = r_low;
                            n_state = S_CHECK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_state = go ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_status = 1'b0;
                n_seq    = r_cur;
                n_ref    = i_rdata[DESC_W-1:LEN_W];
                n_len    = i_rdata[LEN_W-1:0];
                n_last   = !more;
                n_cur    = r_cur + SEQ_W'(1);
                n_k      = k_next;
                if (!r_retx) begin
                    n_high = r_high + SEQ_W'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (res_fire) begin
                    n_state = r_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_retx   <= 1'b0;
            r_low    <= SEQ_W'(1);
            r_high   <= SEQ_W'(1);
            r_stored <= '0;
            r_cur    <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_retx   <= n_retx;
            r_low    <= n_low;
            r_high   <= n_high;
            r_stored <= n_stored;
            r_cur    <= n_cur;
            r_k      <= n_k;
        end
        r_status <= n_status;
        r_seq    <= n_seq;
        r_ref    <= n_ref;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = (r_state == S_OUT);
    assign o_res.status  = r_status;
    assign o_res.seq_num = r_seq;
    assign o_res.tx_ref  = r_ref;
    assign o_res.tx_len  = r_len;
    assign o_res.last    = r_last;

endmodule

`default_nettype wire

>>> design/go_back_n_sender.sv
// Go-back-N transmit window controller. Each request is a send, an ack or a timeout; the
// block answers with the frames to put on the line, one result per frame, with last set on
// the final result of a request (a send into a full 16-entry store gives a single drop result
// with status 1). Descriptors live in a 16 x 41 store with a registered read. A request is
// taken in the idle state, then the check state tests the window, then each frame passes
// through the read state (store read) and then the output state (output register), which
// holds while the sink keeps ready low. A new request is taken only once the last result
// of the previous one has been accepted. The window size register sits at byte address 0
// of the APB port and may only be written while the block is idle.
`default_nettype none

module go_back_n_sender import gbn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gbn_req_if.sink                i_req,
    gbn_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready
);

    logic [CNT_W-1:0]  win;
    t_ram_req          ram_req;
    logic [DESC_W-1:0] ram_rdata;

    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_win   (win)
    );

    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_res   (o_res),
        .i_win   (win),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    gbn_ram #(
        .WIDTH (DESC_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> design/gbn_checker.sv
`default_nettype none

module gbn_checker import gbn_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_ready,
    input wire logic             i_res_valid,
    input wire logic             i_res_ready,
    input wire logic             i_res_status,
    input wire logic [SEQ_W-1:0] i_res_seq_num,
    input wire logic [REF_W-1:0] i_res_tx_ref,
    input wire logic [LEN_W-1:0] i_res_tx_len,
    input wire logic             i_res_last
);

    // No new request is taken while a result of the previous one is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_req_ready)
        else $error("request accepted while a result is pending");

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status) |->
            (i_res_seq_num == '0 && i_res_tx_ref == '0 && i_res_tx_len == '0 && i_res_last))
        else $error("drop result carries frame data");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_status) |-> (32'(i_res_tx_len) <= 32'(MAX_FRAME_BYTES)))
        else $error("transmitted length above the frame limit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && i_res_last) |=> !i_res_valid)
        else $error("result follows the last result of a request");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_seq_num) && $stable(i_res_last)))
        else $error("stalled result changed");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_status  (o_res.status),
    .i_res_seq_num (o_res.seq_num),
    .i_res_tx_ref  (o_res.tx_ref),
    .i_res_tx_len  (o_res.tx_len),
    .i_res_last    (o_res.last)
);

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 24;
    localparam int TAIL_CYCLES     = 40;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_ITEMS      = 30;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 54;

    localparam logic [APB_AW-1:0] WIN_ADDR = {REG_WINDOW_SIZE, 2'b00};

    typedef struct {
        logic             status;
        logic [SEQ_W-1:0] seq;
        logic [REF_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_tx_frame;

    // Tracks the sender window and the descriptor store, and holds the frames
    // that the block is expected to put on the line, oldest first.
    class t_scoreboard;
        logic [CFG_W-1:0] win_reg;
        logic [SEQ_W-1:0] win_low;
        logic [SEQ_W-1:0] win_high;
        logic [SEQ_W-1:0] stored_seq;
        logic [REF_W-1:0] desc_addr [STORE_DEPTH];
        logic [LEN_W-1:0] desc_len [STORE_DEPTH];
        t_tx_frame        expected_tx [$];
        int               errors;

        function new();
            win_reg    = WIN_RESET;
            win_low    = SEQ_W'(1);
            win_high   = SEQ_W'(1);
            stored_seq = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_tx.size();
        endfunction

        function int slot_for(logic [SEQ_W-1:0] seq);
            return int'((seq - SEQ_W'(1)) % STORE_DEPTH);
        endfunction

        function logic [SEQ_W-1:0] window_limit();
            if (win_reg == 0) begin
                return SEQ_W'(1);
            end
            if (win_reg > WINDOW_MAX) begin
                return SEQ_W'(WINDOW_MAX);
            end
            return SEQ_W'(win_reg);
        endfunction

        function void push_frame(logic [SEQ_W-1:0] seq);
            t_tx_frame f;
            int        s;
            s        = slot_for(seq);
            f.status = 1'b0;
            f.seq    = seq;
            f.addr   = desc_addr[s];
            f.len    = desc_len[s];
            f.last   = 1'b0;
            expected_tx.push_back(f);
        endfunction

        function void release_frames();
            while (win_high - SEQ_W'(1) != stored_seq && win_high - win_low < window_limit()) begin
                push_frame(win_high);
                win_high++;
            end
        endfunction

        function void note_request(t_op op, logic [REF_W-1:0] addr, logic [LEN_W-1:0] len,
                                   logic [SEQ_W-1:0] ack);
            int               first;
            logic [SEQ_W-1:0] seq;
            t_tx_frame        drop;
            first = expected_tx.size();
            case (op)
                OP_SEND: begin
                    if (stored_seq - (win_low - SEQ_W'(1)) >= STORE_DEPTH) begin
                        drop.status = 1'b1;
                        drop.seq    = '0;
                        drop.addr   = '0;
                        drop.len    = '0;
                        drop.last   = 1'b0;
                        expected_tx.push_back(drop);
                    end else begin
                        stored_seq++;
                        desc_addr[slot_for(stored_seq)] = addr;
                        desc_len[slot_for(stored_seq)]  =
                            (len > MAX_FRAME_BYTES) ? LEN_W'(MAX_FRAME_BYTES) : len;
                        release_frames();
                    end
                end
                OP_ACK: begin
                    if (ack - win_low < win_high - win_low) begin
                        win_low = ack + SEQ_W'(1);
                        release_frames();
                    end
                end
                OP_TIMEOUT: begin
                    for (seq = win_low; seq != win_high; seq++) begin
                        push_frame(seq);
                    end
                end
                default: begin
                end
            endcase
            if (expected_tx.size() > first) begin
                expected_tx[expected_tx.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_field(string name, logic [31:0] expv, logic [31:0] actv);
            if (expv !== actv) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void check_result(logic status, logic [SEQ_W-1:0] seq, logic [REF_W-1:0] addr,
                                   logic [LEN_W-1:0] len, logic last);
            t_tx_frame e;
            if (expected_tx.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual seq_num %0h status %0b",
                         $time, seq, status);
                errors++;
                return;
            end
            e = expected_tx.pop_front();
            check_field("status", 32'(e.status), 32'(status));
            check_field("seq_num", e.seq, seq);
            check_field("tx_ref", e.addr, addr);
            check_field("tx_len", 32'(e.len), 32'(len));
            check_field("last", 32'(e.last), 32'(last));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    bit                hold_off_req = 1'b0;

    t_scoreboard sb = new();

    gbn_req_if req_ch ();
    gbn_res_if res_ch ();

    go_back_n_sender uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.status, res_ch.seq_num, res_ch.tx_ref, res_ch.tx_len,
                            res_ch.last);
        end
    end

    // The result sink alternates between free-running, random and stalling stretches;
    // on request it holds off for a long stretch so that the block backs up.
    initial begin
        int mode;
        int n;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            mode = $urandom_range(0, 2);
            case (mode)
                0: begin
                    res_ch.ready <= 1'b1;
                    repeat ($urandom_range(5, 40)) @(posedge i_clk);
                end
                1: begin
                    for (n = 0; n < 20; n++) begin
                        res_ch.ready <= 1'($urandom_range(0, 1));
                        @(posedge i_clk);
                    end
                end
                default: begin
                    res_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    res_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
            endcase
        end
    end

    task automatic drive_req(input t_op op, input logic [REF_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] ack);
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.frame_ref <= addr;
        req_ch.frame_len <= len;
        req_ch.ack_num   <= ack;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, addr, len, ack);
    endtask

    task automatic idle_gap(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.win_reg = data[CFG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] expv);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== expv) begin
            $display("%0t: window_size readback mismatch, expected %0h, actual %0h",
                     $time, expv, prdata[CFG_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write(WIN_ADDR, APB_DW'(value));
        apb_check(WIN_ADDR, value);
    endtask

    task automatic pick_request(input int send_pct, output t_op op,
                                output logic [REF_W-1:0] addr, output logic [LEN_W-1:0] len,
                                output logic [SEQ_W-1:0] ack);
        logic [SEQ_W-1:0] span;
        int               pick;
        span = sb.win_high - sb.win_low;
        addr = $urandom;
        ack  = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            len = LEN_W'($urandom_range(MAX_FRAME_BYTES + 1, (1 << LEN_W) - 1));
        end else begin
            len = LEN_W'($urandom_range(0, MAX_FRAME_BYTES));
        end
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < send_pct) begin
            op = OP_SEND;
        end else if (pick < 70) begin
            op = OP_ACK;
        end else if (pick < 92) begin
            op = OP_TIMEOUT;
        end else begin
            op = OP_NONE;
        end
        if (op == OP_ACK) begin
            pick = $urandom_range(0, 99);
            if (span != 0 && pick < 40) begin
                ack = sb.win_high - SEQ_W'(1);
            end else if (span != 0 && pick < 80) begin
                ack = sb.win_low + SEQ_W'($urandom_range(0, span - 1));
            end else begin
                case ($urandom_range(0, 4))
                    0: ack = sb.win_low - SEQ_W'(1);
                    1: ack = sb.win_high;
                    2: ack = sb.win_high + SEQ_W'($urandom_range(1, 1000));
                    3: ack = '1;
                    default: ack = $urandom;
                endcase
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] win_vals [PHASES];
        int               send_pct [PHASES];
        int               phase;
        int               counted;
        int               burst_left;
        int               hold_items;
        int               wait_cnt;
        t_op              op;
        logic [REF_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] ack;

        win_vals = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd4, 4'd7, 4'd8};
        win_vals[4] = CFG_W'($urandom_range(2, 7));
        win_vals[6] = CFG_W'($urandom_range(0, 15));
        send_pct = '{55, 60, 45, 90, 30, 65, 50, 55};

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= OP_NONE;
        req_ch.frame_ref <= '0;
        req_ch.frame_len <= '0;
        req_ch.ack_num   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_check(WIN_ADDR, WIN_RESET);
        @(posedge i_clk);

        // Empty window, ignored codes, length extremes, a full window, a
        // retransmission, stale and future acks, then a store that overflows.
        drive_req(OP_TIMEOUT, $urandom, LEN_W'($urandom), $urandom);
        drive_req(OP_NONE, $urandom, LEN_W'($urandom), $urandom);
        drive_req(OP_SEND, '0, '0, $urandom);
        drive_req(OP_SEND, '1, LEN_W'(MAX_FRAME_BYTES), '0);
        drive_req(OP_SEND, $urandom, '1, $urandom);
        drive_req(OP_SEND, $urandom, LEN_W'(MAX_FRAME_BYTES + 1), $urandom);
        drive_req(OP_SEND, $urandom, LEN_W'($urandom_range(0, MAX_FRAME_BYTES)), $urandom);
        drive_req(OP_TIMEOUT, $urandom, LEN_W'($urandom), $urandom);
        drive_req(OP_ACK, $urandom, LEN_W'($urandom), sb.win_high);
        drive_req(OP_ACK, $urandom, LEN_W'($urandom), '1);
        drive_req(OP_ACK, $urandom, LEN_W'($urandom), '0);
        drive_req(OP_ACK, $urandom, LEN_W'($urandom), sb.win_low + SEQ_W'(1));
        repeat (14) begin
            drive_req(OP_SEND, $urandom, LEN_W'($urandom_range(0, MAX_FRAME_BYTES)), $urandom);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            set_window(win_vals[phase]);
            counted    = 0;
            hold_items = 0;
            burst_left = $urandom_range(1, 16);
            if (phase == 2 || phase == 5) begin
                hold_off_req = 1'b1;
                hold_items   = HOLD_ITEMS;
            end
            while (counted < ITEMS_PER_PHASE) begin
                pick_request(send_pct[phase], op, addr, len, ack);
                if (hold_items > 0) begin
                    hold_items--;
                end else if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end else if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    idle_gap($urandom_range(1, 10));
                end
                drive_req(op, addr, len, ack);
                burst_left--;
                if (op != OP_NONE) begin
                    counted++;
                end
            end
        end

        req_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (sb.pending() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (sb.pending() != 0) begin
            $display("%0t: %0d results still expected at the end", $time, sb.pending());
            $display("tb: failure");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (sb.errors == 0) begin
                $display("tb: success");
            end else begin
                $display("tb: failure");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
